>>> src/pva_pkg.sv
// Shared types and constants for the priority voice allocator.
// Used by pva_cmp, the top level and the checker; depends on nothing.
package pva_pkg;

  localparam int TAG_W             = 31;
  localparam int PRIO_IN_W         = 16;
  localparam int CH_W              = 5;
  localparam int CFG_W             = 6;
  localparam int FRESH_W           = 27;
  localparam int MAX_CHANNELS_DEF  = 32;
  localparam int PRIORITY_BITS_DEF = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET   = 6'd32;
  localparam logic [FRESH_W-1:0] FRESH_RESET = 27'h7FF_FFFF;
  localparam logic [TAG_W-1:0]   SLOT_MASK   = 31'd14;

  typedef enum logic [1:0] {
    MODE_PLAY = 2'd0,
    MODE_STOP = 2'd1,
    MODE_PRIO = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [TAG_W-1:0]      tag;
    logic [PRIO_IN_W-1:0]  priority_req;
    logic [CH_W-1:0]       channel;
  } in_req_t;

  typedef struct packed {
    logic                  accepted;
    logic [CH_W-1:0]       chosen_channel;
    logic [TAG_W-1:0]      assigned_tag;
    logic [TAG_W-1:0]      evicted_tag;
  } out_res_t;

  typedef struct packed {
    logic match;
    logic take;
  } cmp_res_t;

endpackage

>>> src/pva_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> src/pva_cmp.sv
// Shared compare unit: checks one table entry against the request in a scan step.
// Depends on pva_pkg.
module pva_cmp
  import pva_pkg::*;
#(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic [TAG_W-1:0]         entry_tag,
  input  logic [PRIORITY_BITS-1:0] entry_prio,
  input  logic [TAG_W-1:0]         req_tag,
  input  logic [PRIORITY_BITS-1:0] best_prio,
  output cmp_res_t                 res
);

  // The no-interrupt bit takes no part in the tag match.
  assign res.match = (entry_tag[TAG_W-1:1] == req_tag[TAG_W-1:1]);
  // At or below the best so far, so a later entry wins a tie.
  assign res.take  = (entry_prio <= best_prio);

endmodule

>>> src/priority_voice_allocator_top.sv
// Priority voice allocator, top level.
// Depends on pva_pkg, pva_ram and pva_cmp.
//
// Usage. A request is taken at a rising edge where start is high and busy is
// low; in_req carries mode, tag, priority_req and channel. Every request gives
// exactly one result, shown on out_res for a single cycle while out_valid is
// high. The receiver cannot hold results off, so there is no back-pressure.
// The configuration register channels_in_use is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce. Values above MAX_CHANNELS act as MAX_CHANNELS.
//
// Timing. A play request scans the n entries in use one per cycle through a
// single compare unit fed by the table RAM's read port, stopping early on a
// tag match; its result is then registered from S_DONE, and the next request
// can be taken once the block is back in S_IDLE. Stop and refresh requests
// take one table read, issued on acceptance, and their result is registered
// from S_CHAN. A request that names an entry out of range, or an unused mode,
// answers in the next cycle.
//
// Reset. The synchronous active-low reset empties every entry at once by
// clearing per-entry valid bits, reloads the fresh tag counter and sets
// channels_in_use back to 32. There is no clearing pass.
module priority_voice_allocator_top
  import pva_pkg::*;
#(
  parameter int MAX_CHANNELS  = MAX_CHANNELS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             start,
  output logic             busy,
  input  in_req_t          in_req,
  output logic             out_valid,
  output out_res_t         out_res
);

  localparam int AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW     = $clog2(MAX_CHANNELS + 1);
  localparam int PW     = PRIORITY_BITS;
  localparam int ENT_W  = TAG_W + PW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHAN,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [NW-1:0]           rd_idx_r, rd_idx_nxt;
  logic [TAG_W-1:0]        tag_r, tag_nxt;
  logic [PW-1:0]           prio_r, prio_nxt;
  logic [PW-1:0]           best_r, best_nxt;
  logic                    sel_v_r, sel_v_nxt;
  logic [AW-1:0]           sel_idx_r, sel_idx_nxt;
  logic [TAG_W-1:0]        sel_tag_r, sel_tag_nxt;
  logic                    rej_r, rej_nxt;
  logic [FRESH_W-1:0]      cnt_r, cnt_nxt;
  logic [CFG_W-1:0]        cfg_r, cfg_nxt;
  logic [MAX_CHANNELS-1:0] valid_r, valid_nxt;
  logic                    rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]           ch_r, ch_nxt;
  mode_t                   mode_r, mode_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_res_t                out_r, out_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ENT_W-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [ENT_W-1:0]        ram_rdata;

  logic [NW-1:0]           n_act;
  logic [NW-1:0]           rd_idx_inc;
  logic [FRESH_W-1:0]      fresh_cnt;
  logic [PW-1:0]           req_prio;
  logic                    ch_in_range;
  logic [TAG_W-1:0]        entry_tag;
  logic [PW-1:0]           entry_prio;
  cmp_res_t                cmp;

  // Entries beyond the configured count take no part in anything.
  assign n_act = (int'(cfg_r) > MAX_CHANNELS) ? NW'(MAX_CHANNELS) : NW'(cfg_r);
  assign rd_idx_inc  = NW'(rd_idx_r + 1'b1);
  assign fresh_cnt   = cnt_r - 1'b1;
  assign req_prio    = PW'(in_req.priority_req);
  assign ch_in_range = (int'(in_req.channel) < int'(n_act));

  // An entry whose valid bit is clear reads as empty: tag and priority zero.
  assign entry_tag  = rd_ok_r ? ram_rdata[ENT_W-1:PW] : '0;
  assign entry_prio = rd_ok_r ? ram_rdata[PW-1:0]     : '0;

  pva_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pva_cmp #(
    .PRIORITY_BITS (PW)
  ) u_cmp (
    .entry_tag  (entry_tag),
    .entry_prio (entry_prio),
    .req_tag    (tag_r),
    .best_prio  (best_r),
    .res        (cmp)
  );

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    tag_nxt       = tag_r;
    prio_nxt      = prio_r;
    best_nxt      = best_r;
    sel_v_nxt     = sel_v_r;
    sel_idx_nxt   = sel_idx_r;
    sel_tag_nxt   = sel_tag_r;
    rej_nxt       = rej_r;
    cnt_nxt       = cnt_r;
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    valid_nxt     = valid_r;
    ch_nxt        = ch_r;
    mode_nxt      = mode_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = sel_idx_r;
    ram_wdata     = {tag_r, prio_r};
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = (in_req.mode == MODE_PLAY) ? '0 : AW'(in_req.channel);
        if (start) begin
          mode_nxt    = in_req.mode;
          prio_nxt    = req_prio;
          best_nxt    = req_prio;
          sel_v_nxt   = 1'b0;
          rej_nxt     = 1'b0;
          rd_idx_nxt  = '0;
          ch_nxt      = AW'(in_req.channel);
          unique case (in_req.mode)
            MODE_PLAY: begin
              // A tag without slot bits gets a fresh one, even if later rejected.
              if ((in_req.tag & SLOT_MASK) == '0) begin
                cnt_nxt = fresh_cnt;
                tag_nxt = {fresh_cnt, 4'b0000};
              end else begin
                tag_nxt = in_req.tag;
              end
              state_nxt = (n_act == '0) ? S_DONE : S_SCAN;
            end
            MODE_STOP, MODE_PRIO: begin
              if (ch_in_range) begin
                state_nxt = S_CHAN;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt       = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        ram_raddr = AW'(rd_idx_inc);
        if (cmp.match) begin
          sel_v_nxt   = 1'b1;
          sel_idx_nxt = AW'(rd_idx_r);
          sel_tag_nxt = entry_tag;
          rej_nxt     = tag_r[0];
          state_nxt   = S_DONE;
        end else begin
          if (cmp.take) begin
            sel_v_nxt   = 1'b1;
            sel_idx_nxt = AW'(rd_idx_r);
            sel_tag_nxt = entry_tag;
            best_nxt    = entry_prio;
          end
          if (rd_idx_inc == n_act) begin
            state_nxt = S_DONE;
          end else begin
            rd_idx_nxt = rd_idx_inc;
          end
        end
      end

      S_CHAN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (mode_r == MODE_STOP) begin
          valid_nxt[ch_r]        = 1'b0;
          out_nxt.accepted       = 1'b1;
          out_nxt.chosen_channel = CH_W'(ch_r);
          out_nxt.assigned_tag   = '0;
          out_nxt.evicted_tag    = entry_tag;
        end else if (entry_tag != '0) begin
          ram_we                 = 1'b1;
          ram_waddr              = ch_r;
          ram_wdata              = {entry_tag, prio_r};
          out_nxt.accepted       = 1'b1;
          out_nxt.chosen_channel = CH_W'(ch_r);
          out_nxt.assigned_tag   = entry_tag;
          out_nxt.evicted_tag    = '0;
        end else begin
          out_nxt = '0;
        end
      end

      S_DONE: begin
        out_valid_nxt        = 1'b1;
        state_nxt            = S_IDLE;
        out_nxt.assigned_tag = tag_r;
        if (sel_v_r && !rej_r) begin
          ram_we                 = 1'b1;
          valid_nxt[sel_idx_r]   = 1'b1;
          out_nxt.accepted       = 1'b1;
          out_nxt.chosen_channel = CH_W'(sel_idx_r);
          out_nxt.evicted_tag    = sel_tag_r;
        end else begin
          out_nxt.accepted       = 1'b0;
          out_nxt.chosen_channel = '0;
          out_nxt.evicted_tag    = '0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The valid bit follows the read address so it lines up with the RAM data.
    rd_ok_nxt = (int'(ram_raddr) < MAX_CHANNELS) ? valid_r[ram_raddr] : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= FRESH_RESET;
      cfg_r       <= CFG_RESET;
      valid_r     <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      tag_r       <= tag_nxt;
      prio_r      <= prio_nxt;
      best_r      <= best_nxt;
      sel_v_r     <= sel_v_nxt;
      sel_idx_r   <= sel_idx_nxt;
      sel_tag_r   <= sel_tag_nxt;
      rej_r       <= rej_nxt;
      cnt_r       <= cnt_nxt;
      cfg_r       <= cfg_nxt;
      valid_r     <= valid_nxt;
      rd_ok_r     <= rd_ok_nxt;
      ch_r        <= ch_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

>>> src/pva_checker.sv
// Port-level assertions for the priority voice allocator, bound to its top level.
// Depends on pva_pkg and priority_voice_allocator_top.
module pva_checker
  import pva_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input out_res_t out_res
);

  // An accepted request either keeps the block busy or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted request neither started work nor answered");

  // A result is only shown once the work on its request has finished.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // A refused request names no entry and evicts nothing.
  a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.accepted |->
      out_res.chosen_channel == '0 && out_res.evicted_tag == '0)
    else $error("rejected result carries an entry or evicted tag");

  // Work only begins on a request that was offered.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind priority_voice_allocator_top pva_checker u_pva_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
